@@ design/gpc_pkg.sv @@
// Package for the grouped plane contraction block: sizes, codes, payload types
// and small helper functions. It depends on nothing else.
package gpc_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int VALUE_BITS  = 16;
  localparam int MAX_DIM     = 64;

  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 12;
  localparam int IN_VAL_W    = 16;
  localparam int RES_W       = 48;
  localparam int PROD_W      = 2 * VALUE_BITS;
  localparam int DIM_W       = 7;
  localparam int MODE_W      = 2;
  localparam int CMD_W       = 2;
  localparam int SIZE_W      = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_C = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE   = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic [IDX_W-1:0]           flat_index;
    logic signed [IN_VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [IDX_W-1:0]        result_index;
    logic                    index_error;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  nb;
    logic [DIM_W-1:0]  ng;
    logic [DIM_W-1:0]  ni;
    logic [DIM_W-1:0]  no;
    logic [DIM_W-1:0]  ns;
    logic [DIM_W-1:0]  nl;
  } cfg_t;

  // One decoded request as it travels from the front to the back.
  typedef struct packed {
    logic                         is_read;
    logic [CMD_W-1:0]             store_sel;
    logic [IDX_W-1:0]             index;
    logic signed [VALUE_BITS-1:0] value;
  } work_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              full;
  } queue_status_t;

  // Keep the low VALUE_BITS bits of the sign-extended load value.
  function automatic logic signed [VALUE_BITS-1:0] fit_value(
    input logic signed [IN_VAL_W-1:0] v
  );
    logic signed [63:0] w;
    w = 64'(v);
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

@@ design/gpc_front.sv @@
// Front stage of the grouped plane contraction block: accepts requests and
// decodes them into work items. Depends on gpc_pkg.
module gpc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gpc_pkg::in_item_t in_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output gpc_pkg::work_t   work_o,
  output logic             work_valid_o,
  input  logic             work_ready_i
);
  import gpc_pkg::*;

  logic  vld_q, vld_d;
  work_t item_q, item_d;

  assign in_ready_o   = !vld_q || work_ready_i;
  assign work_valid_o = vld_q;
  assign work_o       = item_q;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (in_valid_i && in_ready_o) begin
      vld_d            = 1'b1;
      item_d.is_read   = (in_data_i.cmd == CMD_READ);
      item_d.store_sel = in_data_i.cmd;
      item_d.index     = in_data_i.flat_index;
      item_d.value     = fit_value(in_data_i.value);
    end else if (work_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      item_q <= '0;
    end else begin
      vld_q  <= vld_d;
      item_q <= item_d;
    end
  end

endmodule

@@ design/gpc_queue.sv @@
// Short work queue between the front and the back of the grouped plane
// contraction block. Depends on gpc_pkg.
module gpc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gpc_pkg::work_t        push_data_i,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  output gpc_pkg::work_t        pop_data_o,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output gpc_pkg::queue_status_t status_o
);
  import gpc_pkg::*;

  work_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o    = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o     = (cnt_q != '0);
  assign pop_data_o      = slot_q[rd_q];
  assign push            = push_valid_i && push_ready_o;
  assign pop             = pop_valid_o && pop_ready_i;
  assign status_o.level  = cnt_q;
  assign status_o.full   = !push_ready_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ design/gpc_back.sv @@
// Back end of the grouped plane contraction block: the three element stores,
// the sequencer that sizes, decomposes, addresses and sums, and the output
// register. Depends on gpc_pkg.
module gpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpc_pkg::cfg_t      cfg_i,
  input  gpc_pkg::work_t     work_i,
  input  logic               work_valid_i,
  output logic               work_ready_o,
  output gpc_pkg::out_item_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import gpc_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SIZE   = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_ADDR   = 4'd4;
  localparam logic [3:0] ST_STRIDE = 4'd5;
  localparam logic [3:0] ST_MAC    = 4'd6;
  localparam logic [3:0] ST_DRAIN  = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;

  localparam int N_EVAL = 6;

  typedef struct packed {
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] g;
    logic [ADDR_W-1:0] i;
    logic [ADDR_W-1:0] o;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] l;
  } coord_t;

  logic signed [VALUE_BITS-1:0] a_mem [STORE_DEPTH];
  logic signed [VALUE_BITS-1:0] b_mem [STORE_DEPTH];
  logic signed [VALUE_BITS-1:0] c_mem [STORE_DEPTH];
  logic signed [VALUE_BITS-1:0] a_rd_q, b_rd_q, c_rd_q;
  logic [ADDR_W-1:0]            a_raddr, b_raddr, c_raddr, waddr;
  logic                         a_we, b_we, c_we;

  logic [3:0]        state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [3:0]        bit_q, bit_d;
  logic [2:0]        ev_q, ev_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] sz_q, sz_d;
  logic [DIM_W-1:0]  r_q, r_d;
  logic [IDX_W-1:0]  t_q, t_d;
  logic [DIM_W-1:0]  dig_q [4];
  logic [DIM_W-1:0]  dig_d [4];
  logic [ADDR_W-1:0] ch_q, ch_d;
  logic [ADDR_W-1:0] evr_q [N_EVAL];
  logic [ADDR_W-1:0] evr_d [N_EVAL];
  logic [ADDR_W-1:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic [ADDR_W-1:0] xsi_q, xsi_d, ysi_q, ysi_d, xso_q, xso_d, yso_q, yso_d;
  logic [DIM_W-1:0]  cin_q, cin_d, cout_q, cout_d;
  logic              rd_v_q, rd_v_d, pr_v_q, pr_v_d;
  logic signed [PROD_W-1:0] pr_q, pr_d;
  logic signed [RES_W-1:0]  acc_q, acc_d;
  logic              err_q, err_d;
  logic              ov_q, ov_d;
  out_item_t         out_q, out_d;

  logic [DIM_W-1:0]  nb, ng, ni, no, ns, nl;
  logic [DIM_W-1:0]  size_f, div_f, f_sel, n_in, n_out;
  logic [DIM_W:0]    rr, rsub;
  logic              ge, issue, mode_ok;
  logic [1:0]        ctype;
  logic              inner_one, outer_one;
  coord_t            cc;
  logic [ADDR_W-1:0] x_sel;
  logic [2:0]        n_eval;
  logic signed [VALUE_BITS-1:0] x_rd, y_rd;

  assign nb = dim_clamp(cfg_i.nb);
  assign ng = dim_clamp(cfg_i.ng);
  assign ni = dim_clamp(cfg_i.ni);
  assign no = dim_clamp(cfg_i.no);
  assign ns = dim_clamp(cfg_i.ns);
  assign nl = dim_clamp(cfg_i.nl);

  assign mode_ok = (cfg_i.mode == MODE_FWD) || (cfg_i.mode == MODE_DA) ||
                   (cfg_i.mode == MODE_DW);
  assign n_eval  = (cfg_i.mode == MODE_DW) ? 3'd6 : 3'd4;
  assign n_in    = (cfg_i.mode == MODE_FWD) ? ni : (cfg_i.mode == MODE_DA) ? no : ns;
  assign n_out   = (cfg_i.mode == MODE_DW) ? nb : DIM_W'(1);

  // Factors of the output size, one per step.
  always_comb begin
    size_f = DIM_W'(1);
    unique case (step_q)
      3'd0: size_f = (cfg_i.mode == MODE_DW) ? ng : nb;
      3'd1: size_f = (cfg_i.mode == MODE_DW) ? no : ng;
      3'd2: size_f = (cfg_i.mode == MODE_FWD) ? no : ni;
      3'd3: size_f = (cfg_i.mode == MODE_DW) ? nl : ns;
      3'd4: size_f = (cfg_i.mode == MODE_DW) ? DIM_W'(1) : nl;
      default: size_f = DIM_W'(1);
    endcase
    if (!mode_ok) begin
      size_f = DIM_W'(1);
    end
  end

  // Divisors that peel the flat index apart, innermost first.
  always_comb begin
    div_f = DIM_W'(1);
    unique case (step_q[1:0])
      2'd0: div_f = nl;
      2'd1: div_f = (cfg_i.mode == MODE_DW) ? ni : ns;
      2'd2: div_f = (cfg_i.mode == MODE_DA) ? ni : no;
      2'd3: div_f = (cfg_i.mode == MODE_DW) ? DIM_W'(1) : ng;
      default: div_f = DIM_W'(1);
    endcase
  end

  assign rr   = {r_q, t_q[IDX_W-1]};
  assign rsub = rr - {1'b0, div_f};
  assign ge   = (rr >= {1'b0, div_f});

  // Coordinates of the evaluated element: the summed index is zero, or one
  // when a stride is being measured.
  always_comb begin
    inner_one = (ev_q == 3'd1) || (ev_q == 3'd3);
    outer_one = (ev_q == 3'd4) || (ev_q == 3'd5);
    cc.l = ADDR_W'(dig_q[0]);
    cc.b = ADDR_W'(t_q);
    cc.g = ADDR_W'(dig_q[3]);
    cc.s = ADDR_W'(dig_q[1]);
    cc.i = ADDR_W'(dig_q[2]);
    cc.o = ADDR_W'(dig_q[2]);
    unique case (cfg_i.mode)
      MODE_FWD: cc.i = ADDR_W'(inner_one);
      MODE_DA:  cc.o = ADDR_W'(inner_one);
      default: begin
        cc.i = ADDR_W'(dig_q[1]);
        cc.g = ADDR_W'(t_q);
        cc.s = ADDR_W'(inner_one);
        cc.b = ADDR_W'(outer_one);
      end
    endcase
    if ((ev_q == 3'd0) || (ev_q == 3'd1) || (ev_q == 3'd4)) begin
      ctype = (cfg_i.mode == MODE_DA) ? CH_C : CH_A;
    end else begin
      ctype = (cfg_i.mode == MODE_DW) ? CH_C : CH_B;
    end
  end

  // Horner terms of the row-major address for the chosen tensor.
  always_comb begin
    x_sel = '0;
    f_sel = DIM_W'(1);
    unique case (step_q)
      3'd0: x_sel = (ctype == CH_B) ? '0 : cc.b;
      3'd1: begin
        x_sel = cc.g;
        f_sel = (ctype == CH_B) ? DIM_W'(1) : ng;
      end
      3'd2: begin
        x_sel = (ctype == CH_A) ? cc.i : cc.o;
        f_sel = (ctype == CH_A) ? ni : no;
      end
      3'd3: begin
        x_sel = (ctype == CH_B) ? cc.i : cc.s;
        f_sel = (ctype == CH_B) ? ni : ns;
      end
      default: begin
        x_sel = cc.l;
        f_sel = nl;
      end
    endcase
  end

  assign issue   = (state_q == ST_MAC);
  assign a_raddr = xa_q;
  assign b_raddr = ya_q;
  assign c_raddr = (cfg_i.mode == MODE_DA) ? xa_q : ya_q;
  assign x_rd    = (cfg_i.mode == MODE_DA) ? c_rd_q : a_rd_q;
  assign y_rd    = (cfg_i.mode == MODE_DW) ? c_rd_q : b_rd_q;

  assign work_ready_o = (state_q == ST_IDLE);
  assign waddr        = work_i.index[ADDR_W-1:0];
  assign a_we = (state_q == ST_IDLE) && work_valid_i && !work_i.is_read &&
                (work_i.store_sel == CMD_LOAD_A);
  assign b_we = (state_q == ST_IDLE) && work_valid_i && !work_i.is_read &&
                (work_i.store_sel == CMD_LOAD_B);
  assign c_we = (state_q == ST_IDLE) && work_valid_i && !work_i.is_read &&
                (work_i.store_sel == CMD_LOAD_C);

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    ev_d    = ev_q;
    idx_d   = idx_q;
    sz_d    = sz_q;
    r_d     = r_q;
    t_d     = t_q;
    dig_d   = dig_q;
    ch_d    = ch_q;
    evr_d   = evr_q;
    xa_d    = xa_q;
    ya_d    = ya_q;
    xb_d    = xb_q;
    yb_d    = yb_q;
    xsi_d   = xsi_q;
    ysi_d   = ysi_q;
    xso_d   = xso_q;
    yso_d   = yso_q;
    cin_d   = cin_q;
    cout_d  = cout_q;
    err_d   = err_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_ready_i;
    rd_v_d  = issue;
    pr_v_d  = rd_v_q;
    pr_d    = PROD_W'(x_rd) * PROD_W'(y_rd);
    acc_d   = pr_v_q ? acc_q + RES_W'(pr_q) : acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (work_valid_i && work_i.is_read) begin
          idx_d   = work_i.index;
          sz_d    = SIZE_W'(1);
          step_d  = '0;
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        sz_d   = SIZE_W'(sz_q * size_f);
        step_d = step_q + 1'b1;
        if (step_q == 3'd4) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        acc_d = '0;
        if (!mode_ok || (SIZE_W'(idx_q) >= sz_q)) begin
          err_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          err_d   = 1'b0;
          t_d     = idx_q;
          r_d     = '0;
          step_d  = '0;
          bit_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        r_d   = ge ? rsub[DIM_W-1:0] : rr[DIM_W-1:0];
        t_d   = {t_q[IDX_W-2:0], ge};
        bit_d = bit_q + 1'b1;
        if (bit_q == 4'(IDX_W - 1)) begin
          bit_d               = '0;
          dig_d[step_q[1:0]]  = ge ? rsub[DIM_W-1:0] : rr[DIM_W-1:0];
          r_d                 = '0;
          step_d              = step_q + 1'b1;
          if (step_q == 3'd3) begin
            step_d  = '0;
            ev_d    = '0;
            state_d = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        if (step_q == 3'd0) begin
          ch_d = x_sel;
        end else begin
          ch_d = ADDR_W'(ch_q * f_sel) + x_sel;
        end
        step_d = step_q + 1'b1;
        if (step_q == 3'd4) begin
          step_d     = '0;
          evr_d[ev_q] = ADDR_W'(ch_q * f_sel) + x_sel;
          ev_d       = ev_q + 1'b1;
          if (ev_q == n_eval - 1'b1) begin
            state_d = ST_STRIDE;
          end
        end
      end
      ST_STRIDE: begin
        xa_d   = evr_q[0];
        xb_d   = evr_q[0];
        ya_d   = evr_q[2];
        yb_d   = evr_q[2];
        xsi_d  = evr_q[1] - evr_q[0];
        ysi_d  = evr_q[3] - evr_q[2];
        xso_d  = evr_q[4] - evr_q[0];
        yso_d  = evr_q[5] - evr_q[2];
        cin_d  = '0;
        cout_d = '0;
        if ((n_in == '0) || (n_out == '0)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cin_q != n_in - 1'b1) begin
          cin_d = cin_q + 1'b1;
          xa_d  = xa_q + xsi_q;
          ya_d  = ya_q + ysi_q;
        end else begin
          cin_d = '0;
          if (cout_q == n_out - 1'b1) begin
            state_d = ST_DRAIN;
          end else begin
            cout_d = cout_q + 1'b1;
            xb_d   = xb_q + xso_q;
            yb_d   = yb_q + yso_q;
            xa_d   = xb_q + xso_q;
            ya_d   = yb_q + yso_q;
          end
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !pr_v_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d               = 1'b1;
          out_d.result       = err_q ? '0 : acc_q;
          out_d.result_index = idx_q;
          out_d.index_error  = err_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
      ev_q    <= '0;
      rd_v_q  <= 1'b0;
      pr_v_q  <= 1'b0;
      ov_q    <= 1'b0;
      cin_q   <= '0;
      cout_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      ev_q    <= ev_d;
      rd_v_q  <= rd_v_d;
      pr_v_q  <= pr_v_d;
      ov_q    <= ov_d;
      cin_q   <= cin_d;
      cout_q  <= cout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sz_q  <= sz_d;
    r_q   <= r_d;
    t_q   <= t_d;
    dig_q <= dig_d;
    ch_q  <= ch_d;
    evr_q <= evr_d;
    xa_q  <= xa_d;
    ya_q  <= ya_d;
    xb_q  <= xb_d;
    yb_q  <= yb_d;
    xsi_q <= xsi_d;
    ysi_q <= ysi_d;
    xso_q <= xso_d;
    yso_q <= yso_d;
    pr_q  <= pr_d;
    acc_q <= acc_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[waddr] <= work_i.value;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[waddr] <= work_i.value;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[waddr] <= work_i.value;
    end
    c_rd_q <= c_mem[c_raddr];
  end

endmodule

@@ design/grouped_plane_contraction.sv @@
// Top level of the grouped plane contraction block: configuration registers,
// front, work queue and back. Depends on gpc_pkg, gpc_front, gpc_queue, gpc_back.
// A load passes the front register and a queue slot before it is written, and
// waits in the queue while the back is busy with a read. A read sizes the
// output, checks the index, splits it into four digits, forms four element
// addresses (six in mode 2), derives strides and sums in_channels products in
// mode 0, out_channels in mode 1 or batch times spatial in mode 2. A bad index
// or mode is flagged with a zero result. Loads are taken one per cycle while the
// back is idle; a read holds the back until it is answered. Reset clears the
// control state and sets mode 0 and all sizes to 1. The stores are not cleared.
module grouped_plane_contraction (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gpc_pkg::in_item_t                   in_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  output gpc_pkg::out_item_t                  out_data_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic                                cfg_we_i,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gpc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import gpc_pkg::*;

  cfg_t          cfg_q, cfg_d;
  work_t         fw_data, qb_data;
  logic          fw_valid, fw_ready, qb_valid, qb_ready;
  queue_status_t q_status;

  // Configuration registers. Writes to an index past the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:    cfg_d.mode = cfg_wdata_i[MODE_W-1:0];
        CFG_BATCH:   cfg_d.nb   = cfg_wdata_i[DIM_W-1:0];
        CFG_GROUP:   cfg_d.ng   = cfg_wdata_i[DIM_W-1:0];
        CFG_IN_CH:   cfg_d.ni   = cfg_wdata_i[DIM_W-1:0];
        CFG_OUT_CH:  cfg_d.no   = cfg_wdata_i[DIM_W-1:0];
        CFG_SPATIAL: cfg_d.ns   = cfg_wdata_i[DIM_W-1:0];
        CFG_PLANE:   cfg_d.nl   = cfg_wdata_i[DIM_W-1:0];
        default:     cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_FWD;
      cfg_q.nb   <= DIM_W'(1);
      cfg_q.ng   <= DIM_W'(1);
      cfg_q.ni   <= DIM_W'(1);
      cfg_q.no   <= DIM_W'(1);
      cfg_q.ns   <= DIM_W'(1);
      cfg_q.nl   <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front decodes each request; the queue lets it keep taking requests
  // while the back is busy with a long read, until the queue is full.
  gpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .work_o       (fw_data),
    .work_valid_o (fw_valid),
    .work_ready_i (fw_ready)
  );

  gpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (fw_data),
    .push_valid_i (fw_valid),
    .push_ready_o (fw_ready),
    .pop_data_o   (qb_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .status_o     (q_status)
  );

  // The back owns the stores and carries out loads and reads in order.
  gpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_i       (qb_data),
    .work_valid_i (qb_valid),
    .work_ready_o (qb_ready),
    .out_data_o   (out_data_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  a_mode_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == CFG_MODE) |=>
      cfg_q.mode == $past(cfg_wdata_i[MODE_W-1:0]))
    else $error("mode register did not take the write");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.index_error |-> out_data_o.result == '0)
    else $error("flagged result is not zero");

  a_queue_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.level <= QCNT_W'(QUEUE_DEPTH) && (q_status.full == !fw_ready))
    else $error("work queue level out of range");

endmodule
